FILE: src/wwlp_pkg.sv
// ============================================================================
// wwlp_pkg
// Shared types and constants for the word-wrap layout placer.
// ============================================================================
package wwlp_pkg;

   // default parameter values
   localparam int Y_BITS_DEF        = 20;
   localparam int WORD_LEN_BITS_DEF = 8;

   // token codes on the request side
   localparam logic [2:0] ACT_WORD  = 3'd0;
   localparam logic [2:0] ACT_SPACE = 3'd1;
   localparam logic [2:0] ACT_LINE  = 3'd2;
   localparam logic [2:0] ACT_PARA  = 3'd3;
   localparam logic [2:0] ACT_IMAGE = 3'd4;
   localparam logic [2:0] ACT_END   = 3'd5;

   // result kinds
   localparam logic [1:0] KIND_TEXT  = 2'd0;
   localparam logic [1:0] KIND_IMAGE = 2'd1;
   localparam logic [1:0] KIND_TOTAL = 2'd2;

   // register indexes (byte address / 4)
   localparam logic [2:0] REG_LINE_WIDTH   = 3'd0;
   localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd1;
   localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd2;
   localparam logic [2:0] REG_SCALE_DELTA  = 3'd3;
   localparam logic [2:0] REG_DEF_IMG_H    = 3'd4;

   // register reset values
   localparam logic [11:0]       RST_LINE_WIDTH   = 12'd320;
   localparam logic [5:0]        RST_GLYPH_WIDTH  = 6'd6;
   localparam logic [5:0]        RST_GLYPH_HEIGHT = 6'd8;
   localparam logic signed [8:0] RST_SCALE_DELTA  = 9'sd0;
   localparam logic [11:0]       RST_DEF_IMG_H    = 12'd64;

   // scale in sixteenths
   localparam logic signed [9:0] SCALE_H1    = 10'sd64;
   localparam logic signed [9:0] SCALE_H23   = 10'sd48;
   localparam logic signed [9:0] SCALE_PLAIN = 10'sd32;
   localparam logic signed [9:0] SCALE_MIN   = 10'sd8;
   localparam logic signed [9:0] SCALE_MAX   = 10'sd128;

   localparam logic [8:0]  LINE_GAP = 9'd2;
   localparam logic [11:0] PARA_GAP = 12'd6;

   typedef struct packed {
      logic [11:0]       line_width;
      logic [5:0]        glyph_width;
      logic [5:0]        glyph_height;
      logic signed [8:0] scale_delta;
      logic [11:0]       default_image_height;
   } cfg_type;

endpackage

FILE: src/wwlp_mul.sv
// ============================================================================
// wwlp_mul
// Shared multiplier of the placer: one unsigned product per cycle, registered.
// ============================================================================
module wwlp_mul #(
   parameter int A_W = 14
) (
   input  logic                 clock,
   input  logic [A_W-1:0]       op_a,
   input  logic [7:0]           op_b,
   output logic [A_W+7:0]       prod_ff
);

   logic [A_W+7:0] prod_in;

   assign prod_in = (A_W+8)'(op_a) * (A_W+8)'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

FILE: src/wwlp_core.sv
// ============================================================================
// wwlp_core
// Sequencer of the placer: sizes a token on the shared multiplier, moves the
// pen and, for a word, image or end, emits a beat into the result register.
// ============================================================================
module wwlp_core #(
   parameter int Y_BITS        = wwlp_pkg::Y_BITS_DEF,
   parameter int WORD_LEN_BITS = wwlp_pkg::WORD_LEN_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  wwlp_pkg::cfg_type         cfg,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_action,
   input  logic [2:0]                req_heading_level,
   input  logic [WORD_LEN_BITS-1:0]  req_word_length,
   input  logic [15:0]               req_text_offset,
   input  logic [15:0]               req_item_index,
   input  logic signed [15:0]        req_link_index,
   input  logic [14:0]               req_image_index,
   input  logic [11:0]               req_image_height,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_kind,
   output logic [11:0]               rsp_pos_x,
   output logic [Y_BITS-1:0]         rsp_pos_y,
   output logic [11:0]               rsp_row_line_height,
   output logic [15:0]               rsp_out_item_index,
   output logic [15:0]               rsp_out_text_offset,
   output logic [WORD_LEN_BITS-1:0]  rsp_out_word_length,
   output logic [2:0]                rsp_out_heading_level,
   output logic signed [15:0]        rsp_out_link_index,
   output logic signed [15:0]        rsp_out_image_index
);

   localparam int A_W = WORD_LEN_BITS + 6;
   localparam int P_W = A_W + 8;
   localparam int W_W = P_W - 3;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MBASE  = 4'd1;
   localparam logic [3:0] ST_MLINE  = 4'd2;
   localparam logic [3:0] ST_MCHAR  = 4'd3;
   localparam logic [3:0] ST_MWIDTH = 4'd4;
   localparam logic [3:0] ST_PLACE  = 4'd5;
   localparam logic [3:0] ST_WORD   = 4'd6;
   localparam logic [3:0] ST_WRAP   = 4'd7;
   localparam logic [3:0] ST_PARA   = 4'd8;
   localparam logic [3:0] ST_IMAGE  = 4'd9;
   localparam logic [3:0] ST_END    = 4'd10;

   function automatic logic [7:0] scale16(input logic [2:0] lvl,
                                          input logic signed [8:0] d);
      logic signed [9:0] base;
      logic signed [9:0] s;
      begin
         base = wwlp_pkg::SCALE_PLAIN;
         if (lvl == 3'd1) begin
            base = wwlp_pkg::SCALE_H1;
         end else if (lvl inside {3'd2, 3'd3}) begin
            base = wwlp_pkg::SCALE_H23;
         end
         s = base + {d[8], d};
         if (s < wwlp_pkg::SCALE_MIN) s = wwlp_pkg::SCALE_MIN;
         if (s > wwlp_pkg::SCALE_MAX) s = wwlp_pkg::SCALE_MAX;
         return s[7:0];
      end
   endfunction

   // control
   logic [3:0]               state_ff, state_in;
   logic [11:0]              pen_x_ff, pen_x_in;
   logic [Y_BITS-1:0]        pen_y_ff, pen_y_in;
   logic [8:0]               tallest_ff, tallest_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // latched token and sizes
   logic [2:0]               act_ff, act_in;
   logic [2:0]               lvl_ff, lvl_in;
   logic [WORD_LEN_BITS-1:0] wlen_ff, wlen_in;
   logic [15:0]              toff_ff, toff_in;
   logic [15:0]              item_ff, item_in;
   logic signed [15:0]       link_ff, link_in;
   logic [14:0]              img_ff, img_in;
   logic [11:0]              imh_ff, imh_in;
   logic [7:0]               s_lvl_ff, s_lvl_in;
   logic [7:0]               s_plain_ff, s_plain_in;
   logic [8:0]               base_lh_ff, base_lh_in;
   logic [8:0]               line_h_ff, line_h_in;
   logic [W_W-1:0]           wpx_ff, wpx_in;

   // result register
   logic [1:0]               kind_ff, kind_in;
   logic [11:0]              ox_ff, ox_in;
   logic [Y_BITS-1:0]        oy_ff, oy_in;
   logic [11:0]              olh_ff, olh_in;
   logic [15:0]              oitem_ff, oitem_in;
   logic [15:0]              otoff_ff, otoff_in;
   logic [WORD_LEN_BITS-1:0] owlen_ff, owlen_in;
   logic [2:0]               olvl_ff, olvl_in;
   logic signed [15:0]       olink_ff, olink_in;
   logic signed [15:0]       oimg_ff, oimg_in;

   // shared datapath
   logic [A_W-1:0]           mul_a;
   logic [7:0]               mul_b;
   logic [P_W-1:0]           prod;
   logic [P_W:0]             rnd_sum;
   logic [W_W-1:0]           rnd;
   logic [W_W-1:0]           x_add;
   logic [W_W:0]             x_sum;
   logic                     x_over;
   logic [11:0]              dy;
   logic [Y_BITS:0]          y_sum;
   logic [Y_BITS-1:0]        y_sat;
   logic [8:0]               fallback;
   logic [11:0]              close_dy;
   logic [11:0]              box;
   logic                     accept;
   logic                     out_free;

   wwlp_mul #(.A_W(A_W)) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign rnd_sum = {1'b0, prod} + (P_W+1)'(8);
   assign rnd     = rnd_sum[P_W:4];

   // pen x adder: the fresh width while placing, the held width after
   assign x_add  = (state_ff == ST_PLACE) ? rnd : wpx_ff;
   assign x_sum  = {1'b0, x_add} + (W_W+1)'(pen_x_ff);
   assign x_over = x_sum > (W_W+1)'(cfg.line_width);

   assign fallback = (act_ff == wwlp_pkg::ACT_WORD || act_ff == wwlp_pkg::ACT_SPACE)
                     ? line_h_ff : base_lh_ff;
   assign close_dy = (tallest_ff != 9'd0) ? 12'(tallest_ff) : 12'(fallback);
   assign box      = (imh_ff != 12'd0) ? imh_ff : cfg.default_image_height;

   assign y_sum = {1'b0, pen_y_ff} + (Y_BITS+1)'(dy);
   assign y_sat = y_sum[Y_BITS] ? {Y_BITS{1'b1}} : y_sum[Y_BITS-1:0];

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MBASE: begin
            mul_a = A_W'(cfg.glyph_height);
            mul_b = s_plain_ff;
         end
         ST_MLINE: begin
            mul_a = A_W'(cfg.glyph_height);
            mul_b = s_lvl_ff;
         end
         ST_MCHAR: begin
            mul_a = (act_ff == wwlp_pkg::ACT_WORD) ? A_W'(wlen_ff) : A_W'(1);
            mul_b = 8'(cfg.glyph_width);
         end
         ST_MWIDTH: begin
            mul_a = prod[A_W-1:0];
            mul_b = s_lvl_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      tallest_in   = tallest_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      act_in       = act_ff;
      lvl_in       = lvl_ff;
      wlen_in      = wlen_ff;
      toff_in      = toff_ff;
      item_in      = item_ff;
      link_in      = link_ff;
      img_in       = img_ff;
      imh_in       = imh_ff;
      s_lvl_in     = s_lvl_ff;
      s_plain_in   = s_plain_ff;
      base_lh_in   = base_lh_ff;
      line_h_in    = line_h_ff;
      wpx_in       = wpx_ff;
      kind_in      = kind_ff;
      ox_in        = ox_ff;
      oy_in        = oy_ff;
      olh_in       = olh_ff;
      oitem_in     = oitem_ff;
      otoff_in     = otoff_ff;
      owlen_in     = owlen_ff;
      olvl_in      = olvl_ff;
      olink_in     = olink_ff;
      oimg_in      = oimg_ff;
      dy           = close_dy;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in     = req_action;
               lvl_in     = req_heading_level;
               wlen_in    = req_word_length;
               toff_in    = req_text_offset;
               item_in    = req_item_index;
               link_in    = req_link_index;
               img_in     = req_image_index;
               imh_in     = req_image_height;
               s_lvl_in   = scale16(req_heading_level, cfg.scale_delta);
               s_plain_in = scale16(3'd0, cfg.scale_delta);
               state_in   = ST_MBASE;
            end
         end
         ST_MBASE: begin
            state_in = ST_MLINE;
         end
         ST_MLINE: begin
            base_lh_in = rnd[8:0] + wwlp_pkg::LINE_GAP;
            state_in   = ST_MCHAR;
         end
         ST_MCHAR: begin
            line_h_in = rnd[8:0] + wwlp_pkg::LINE_GAP;
            state_in  = ST_MWIDTH;
         end
         ST_MWIDTH: begin
            state_in = ST_PLACE;
         end
         ST_PLACE: begin
            wpx_in   = rnd;
            state_in = ST_IDLE;
            case (act_ff)
               wwlp_pkg::ACT_WORD: begin
                  // wrap before the word if it overruns a row that is not empty
                  if (pen_x_ff != 12'd0 && x_over) begin
                     pen_y_in   = y_sat;
                     pen_x_in   = 12'd0;
                     tallest_in = 9'd0;
                  end
                  state_in = ST_WORD;
               end
               wwlp_pkg::ACT_SPACE: begin
                  if (pen_x_ff != 12'd0) begin
                     if (!x_over) begin
                        pen_x_in = x_sum[11:0];
                     end else begin
                        pen_y_in   = y_sat;
                        pen_x_in   = 12'd0;
                        tallest_in = 9'd0;
                     end
                  end
               end
               wwlp_pkg::ACT_LINE, wwlp_pkg::ACT_PARA: begin
                  pen_y_in   = y_sat;
                  pen_x_in   = 12'd0;
                  tallest_in = 9'd0;
                  if (act_ff == wwlp_pkg::ACT_PARA) state_in = ST_PARA;
               end
               wwlp_pkg::ACT_IMAGE, wwlp_pkg::ACT_END: begin
                  if (pen_x_ff != 12'd0) begin
                     pen_y_in   = y_sat;
                     pen_x_in   = 12'd0;
                     tallest_in = 9'd0;
                  end
                  state_in = (act_ff == wwlp_pkg::ACT_IMAGE) ? ST_IMAGE : ST_END;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_WORD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = wwlp_pkg::KIND_TEXT;
               ox_in        = pen_x_ff;
               oy_in        = pen_y_ff;
               olh_in       = 12'(line_h_ff);
               oitem_in     = item_ff;
               otoff_in     = toff_ff;
               owlen_in     = wlen_ff;
               olvl_in      = lvl_ff;
               olink_in     = link_ff;
               oimg_in      = -16'sd1;
               if (line_h_ff > tallest_ff) tallest_in = line_h_ff;
               if (x_over) begin
                  state_in = ST_WRAP;
               end else begin
                  pen_x_in = x_sum[11:0];
                  state_in = ST_IDLE;
               end
            end
         end
         ST_WRAP: begin
            // tallest is nonzero here, so close_dy picks it
            pen_y_in   = y_sat;
            pen_x_in   = 12'd0;
            tallest_in = 9'd0;
            state_in   = ST_IDLE;
         end
         ST_PARA: begin
            dy       = wwlp_pkg::PARA_GAP;
            pen_y_in = y_sat;
            state_in = ST_IDLE;
         end
         ST_IMAGE: begin
            dy = box;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = wwlp_pkg::KIND_IMAGE;
               ox_in        = 12'd0;
               oy_in        = pen_y_ff;
               olh_in       = box;
               oitem_in     = item_ff;
               otoff_in     = 16'd0;
               owlen_in     = '0;
               olvl_in      = 3'd0;
               olink_in     = -16'sd1;
               oimg_in      = signed'({1'b0, img_ff});
               pen_y_in     = y_sat;
               pen_x_in     = 12'd0;
               tallest_in   = 9'd0;
               state_in     = ST_IDLE;
            end
         end
         ST_END: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = wwlp_pkg::KIND_TOTAL;
               ox_in        = 12'd0;
               oy_in        = pen_y_ff;
               olh_in       = 12'd0;
               oitem_in     = 16'd0;
               otoff_in     = 16'd0;
               owlen_in     = '0;
               olvl_in      = 3'd0;
               olink_in     = -16'sd1;
               oimg_in      = -16'sd1;
               pen_y_in     = '0;
               pen_x_in     = 12'd0;
               tallest_in   = 9'd0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pen_x_ff     <= 12'd0;
         pen_y_ff     <= '0;
         tallest_ff   <= 9'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         tallest_ff   <= tallest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff     <= act_in;
      lvl_ff     <= lvl_in;
      wlen_ff    <= wlen_in;
      toff_ff    <= toff_in;
      item_ff    <= item_in;
      link_ff    <= link_in;
      img_ff     <= img_in;
      imh_ff     <= imh_in;
      s_lvl_ff   <= s_lvl_in;
      s_plain_ff <= s_plain_in;
      base_lh_ff <= base_lh_in;
      line_h_ff  <= line_h_in;
      wpx_ff     <= wpx_in;
      kind_ff    <= kind_in;
      ox_ff      <= ox_in;
      oy_ff      <= oy_in;
      olh_ff     <= olh_in;
      oitem_ff   <= oitem_in;
      otoff_ff   <= otoff_in;
      owlen_ff   <= owlen_in;
      olvl_ff    <= olvl_in;
      olink_ff   <= olink_in;
      oimg_ff    <= oimg_in;
   end

   assign req_ready             = (state_ff == ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_kind              = kind_ff;
   assign rsp_pos_x             = ox_ff;
   assign rsp_pos_y             = oy_ff;
   assign rsp_row_line_height   = olh_ff;
   assign rsp_out_item_index    = oitem_ff;
   assign rsp_out_text_offset   = otoff_ff;
   assign rsp_out_word_length   = owlen_ff;
   assign rsp_out_heading_level = olvl_ff;
   assign rsp_out_link_index    = olink_ff;
   assign rsp_out_image_index   = oimg_ff;

endmodule

FILE: src/word_wrap_layout_placer.sv
// ============================================================================
// word_wrap_layout_placer
// Greedy word-wrap placer: register file and placement sequencer.
// ============================================================================
//  channel   handshake             payload
//  req       req_valid/req_ready   action, heading level, word, pass-through
//  rsp       rsp_valid/rsp_ready   kind, pos x/y, line height, pass-through
//  csr       psel/penable/pready   5 regs at byte addr 4*i, 32-bit data
//
//  Every token makes four passes through the one shared multiplier and a
//  placement step; a word, image or end then adds an emit step, a paragraph
//  break a gap step, and a word that overruns the line a row-close step.
//  The placed beat sits in a result register, so a new token is taken
//  while it waits; a beat that finds the register still full holds the
//  sequencer. Synchronous reset clears the pen and resets the csr regs.
// ============================================================================
module word_wrap_layout_placer #(
   parameter int Y_BITS        = wwlp_pkg::Y_BITS_DEF,
   parameter int WORD_LEN_BITS = wwlp_pkg::WORD_LEN_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [4:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_action,
   input  logic [2:0]                req_heading_level,
   input  logic [WORD_LEN_BITS-1:0]  req_word_length,
   input  logic [15:0]               req_text_offset,
   input  logic [15:0]               req_item_index,
   input  logic signed [15:0]        req_link_index,
   input  logic [14:0]               req_image_index,
   input  logic [11:0]               req_image_height,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_kind,
   output logic [11:0]               rsp_pos_x,
   output logic [Y_BITS-1:0]         rsp_pos_y,
   output logic [11:0]               rsp_row_line_height,
   output logic [15:0]               rsp_out_item_index,
   output logic [15:0]               rsp_out_text_offset,
   output logic [WORD_LEN_BITS-1:0]  rsp_out_word_length,
   output logic [2:0]                rsp_out_heading_level,
   output logic signed [15:0]        rsp_out_link_index,
   output logic signed [15:0]        rsp_out_image_index
);

   wwlp_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]        reg_idx;
   logic              wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            wwlp_pkg::REG_LINE_WIDTH:   cfg_in.line_width           = pwdata[11:0];
            wwlp_pkg::REG_GLYPH_WIDTH:  cfg_in.glyph_width          = pwdata[5:0];
            wwlp_pkg::REG_GLYPH_HEIGHT: cfg_in.glyph_height         = pwdata[5:0];
            wwlp_pkg::REG_SCALE_DELTA:  cfg_in.scale_delta          = signed'(pwdata[8:0]);
            wwlp_pkg::REG_DEF_IMG_H:    cfg_in.default_image_height = pwdata[11:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.line_width           <= wwlp_pkg::RST_LINE_WIDTH;
         cfg_ff.glyph_width          <= wwlp_pkg::RST_GLYPH_WIDTH;
         cfg_ff.glyph_height         <= wwlp_pkg::RST_GLYPH_HEIGHT;
         cfg_ff.scale_delta          <= wwlp_pkg::RST_SCALE_DELTA;
         cfg_ff.default_image_height <= wwlp_pkg::RST_DEF_IMG_H;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         wwlp_pkg::REG_LINE_WIDTH:   prdata = 32'(cfg_ff.line_width);
         wwlp_pkg::REG_GLYPH_WIDTH:  prdata = 32'(cfg_ff.glyph_width);
         wwlp_pkg::REG_GLYPH_HEIGHT: prdata = 32'(cfg_ff.glyph_height);
         wwlp_pkg::REG_SCALE_DELTA:  prdata = 32'(cfg_ff.scale_delta[8:0]);
         wwlp_pkg::REG_DEF_IMG_H:    prdata = 32'(cfg_ff.default_image_height);
         default:                    prdata = 32'd0;
      endcase
   end

   wwlp_core #(
      .Y_BITS        (Y_BITS),
      .WORD_LEN_BITS (WORD_LEN_BITS)
   ) u_core (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg_ff),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_action            (req_action),
      .req_heading_level     (req_heading_level),
      .req_word_length       (req_word_length),
      .req_text_offset       (req_text_offset),
      .req_item_index        (req_item_index),
      .req_link_index        (req_link_index),
      .req_image_index       (req_image_index),
      .req_image_height      (req_image_height),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_kind              (rsp_kind),
      .rsp_pos_x             (rsp_pos_x),
      .rsp_pos_y             (rsp_pos_y),
      .rsp_row_line_height   (rsp_row_line_height),
      .rsp_out_item_index    (rsp_out_item_index),
      .rsp_out_text_offset   (rsp_out_text_offset),
      .rsp_out_word_length   (rsp_out_word_length),
      .rsp_out_heading_level (rsp_out_heading_level),
      .rsp_out_link_index    (rsp_out_link_index),
      .rsp_out_image_index   (rsp_out_image_index)
   );

endmodule

FILE: tb/word_wrap_layout_placer_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// word_wrap_layout_placer_tb
// Self-checking bench for the greedy word-wrap placer. Token streams go in
// on the req channel; every text, image and total beat on the rsp channel is
// checked field by field against a local placement model that tracks pen
// position, row height and the register settings written over the csr port.
// ============================================================================
module word_wrap_layout_placer_tb;

   localparam int WLB             = wwlp_pkg::WORD_LEN_BITS_DEF;
   localparam int YB              = wwlp_pkg::Y_BITS_DEF;
   localparam longint Y_TOP       = (longint'(1) << YB) - 1;
   localparam int SETTLE_CYCLES   = 16;
   localparam int PRESSURE_CYCLES = 500;
   localparam int CYCLE_LIMIT     = 400000;

   // the two action codes the block ignores
   localparam logic [2:0] ACT_SPARE_A = 3'd6;
   localparam logic [2:0] ACT_SPARE_B = 3'd7;

   typedef struct {
      logic [2:0]         action;
      logic [2:0]         level;
      logic [WLB-1:0]     word_length;
      logic [15:0]        txt_pos;
      logic [15:0]        doc_item;
      logic signed [15:0] link_ref;
      logic [14:0]        img_num;
      logic [11:0]        image_height;
   } token_type;

   typedef struct {
      logic [1:0]         kind;
      logic [11:0]        pos_x;
      logic [YB-1:0]      pos_y;
      logic [11:0]        row_h;
      logic [15:0]        doc_item;
      logic [15:0]        txt_pos;
      logic [WLB-1:0]     word_length;
      logic [2:0]         level;
      logic signed [15:0] link_ref;
      logic signed [15:0] img_num;
   } placement_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [4:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_action = wwlp_pkg::ACT_WORD;
   logic [2:0]         req_heading_level = '0;
   logic [WLB-1:0]     req_word_length = '0;
   logic [15:0]        req_text_offset = '0;
   logic [15:0]        req_item_index = '0;
   logic signed [15:0] req_link_index = '0;
   logic [14:0]        req_image_index = '0;
   logic [11:0]        req_image_height = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [1:0]         rsp_kind;
   logic [11:0]        rsp_pos_x;
   logic [YB-1:0]      rsp_pos_y;
   logic [11:0]        rsp_row_line_height;
   logic [15:0]        rsp_out_item_index;
   logic [15:0]        rsp_out_text_offset;
   logic [WLB-1:0]     rsp_out_word_length;
   logic [2:0]         rsp_out_heading_level;
   logic signed [15:0] rsp_out_link_index;
   logic signed [15:0] rsp_out_image_index;

   // placement model state
   wwlp_pkg::cfg_type settings_model = '{wwlp_pkg::RST_LINE_WIDTH,
                                         wwlp_pkg::RST_GLYPH_WIDTH,
                                         wwlp_pkg::RST_GLYPH_HEIGHT,
                                         wwlp_pkg::RST_SCALE_DELTA,
                                         wwlp_pkg::RST_DEF_IMG_H};
   longint  col_px = 0;
   longint  top_px = 0;
   longint  row_peak_px = 0;

   placement_type expected_placements[$];
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   logic          hold_rsp = 1'b0;

   word_wrap_layout_placer dut (
      .clock                 (clock),
      .reset                 (reset),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_action            (req_action),
      .req_heading_level     (req_heading_level),
      .req_word_length       (req_word_length),
      .req_text_offset       (req_text_offset),
      .req_item_index        (req_item_index),
      .req_link_index        (req_link_index),
      .req_image_index       (req_image_index),
      .req_image_height      (req_image_height),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_kind              (rsp_kind),
      .rsp_pos_x             (rsp_pos_x),
      .rsp_pos_y             (rsp_pos_y),
      .rsp_row_line_height   (rsp_row_line_height),
      .rsp_out_item_index    (rsp_out_item_index),
      .rsp_out_text_offset   (rsp_out_text_offset),
      .rsp_out_word_length   (rsp_out_word_length),
      .rsp_out_heading_level (rsp_out_heading_level),
      .rsp_out_link_index    (rsp_out_link_index),
      .rsp_out_image_index   (rsp_out_image_index)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("word_wrap_layout_placer_tb: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !hold_rsp && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------- model

   function automatic longint round_px(input longint p);
      return (p + 8) >>> 4;
   endfunction

   // font scale in sixteenths for a heading level
   function automatic longint scaled16(input logic [2:0] lvl);
      longint s;
      case (lvl)
         3'd1:       s = wwlp_pkg::SCALE_H1;
         3'd2, 3'd3: s = wwlp_pkg::SCALE_H23;
         default:    s = wwlp_pkg::SCALE_PLAIN;
      endcase
      s = s + longint'($signed(settings_model.scale_delta));
      if (s < wwlp_pkg::SCALE_MIN) s = wwlp_pkg::SCALE_MIN;
      if (s > wwlp_pkg::SCALE_MAX) s = wwlp_pkg::SCALE_MAX;
      return s;
   endfunction

   function automatic void move_down(input longint dy);
      top_px = top_px + dy;
      if (top_px > Y_TOP) top_px = Y_TOP;
   endfunction

   // an empty row still advances by the fallback height
   function automatic void drop_row(input longint fallback);
      move_down(row_peak_px > 0 ? row_peak_px : fallback);
      col_px = 0;
      row_peak_px = 0;
   endfunction

   function automatic bit place_token(input token_type t, output placement_type r);
      longint gh;
      longint s;
      longint base_lh;
      longint lh;
      longint adv;
      longint box;
      bit     emits;
      gh      = longint'(settings_model.glyph_height);
      s       = scaled16(t.level);
      base_lh = round_px(gh * scaled16(3'd0)) + wwlp_pkg::LINE_GAP;
      lh      = round_px(gh * s) + wwlp_pkg::LINE_GAP;
      emits   = 1'b0;
      r = '{wwlp_pkg::KIND_TEXT, '0, '0, '0, '0, '0, '0, '0, -16'sd1, -16'sd1};
      case (t.action)
         wwlp_pkg::ACT_WORD: begin
            adv = round_px(longint'(t.word_length) *
                           longint'(settings_model.glyph_width) * s);
            if (col_px > 0 && col_px + adv > settings_model.line_width) drop_row(lh);
            r.kind        = wwlp_pkg::KIND_TEXT;
            r.pos_x       = col_px[11:0];
            r.pos_y       = top_px[YB-1:0];
            r.row_h       = lh[11:0];
            r.doc_item    = t.doc_item;
            r.txt_pos     = t.txt_pos;
            r.word_length = t.word_length;
            r.level       = t.level;
            r.link_ref    = t.link_ref;
            if (lh > row_peak_px) row_peak_px = lh;
            col_px = col_px + adv;
            // overlong word stays where it landed, then the row closes
            if (col_px > settings_model.line_width) drop_row(lh);
            emits = 1'b1;
         end
         wwlp_pkg::ACT_SPACE: begin
            adv = round_px(longint'(settings_model.glyph_width) * s);
            if (col_px > 0) begin
               if (col_px + adv <= settings_model.line_width) col_px = col_px + adv;
               else drop_row(lh);
            end
         end
         wwlp_pkg::ACT_LINE: drop_row(base_lh);
         wwlp_pkg::ACT_PARA: begin
            drop_row(base_lh);
            move_down(wwlp_pkg::PARA_GAP);
         end
         wwlp_pkg::ACT_IMAGE: begin
            box = t.image_height != 0 ? longint'(t.image_height)
                                      : longint'(settings_model.default_image_height);
            if (col_px != 0) drop_row(base_lh);
            r.kind     = wwlp_pkg::KIND_IMAGE;
            r.pos_y    = top_px[YB-1:0];
            r.row_h    = box[11:0];
            r.doc_item = t.doc_item;
            r.img_num  = {1'b0, t.img_num};
            move_down(box);
            col_px = 0;
            row_peak_px = 0;
            emits = 1'b1;
         end
         wwlp_pkg::ACT_END: begin
            if (col_px > 0) drop_row(base_lh);
            r.kind  = wwlp_pkg::KIND_TOTAL;
            r.pos_y = top_px[YB-1:0];
            col_px = 0;
            top_px = 0;
            row_peak_px = 0;
            emits = 1'b1;
         end
         default: ;
      endcase
      return emits;
   endfunction

   // ---------------------------------------------------------------- checker

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : check_beats
      placement_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_placements.size() == 0) begin
            $error("rsp beat with nothing pending: kind %0d pos_y %0d", rsp_kind, rsp_pos_y);
            mismatch_count++;
         end else begin
            e = expected_placements.pop_front();
            check_field("kind", e.kind, rsp_kind);
            check_field("pos_x", e.pos_x, rsp_pos_x);
            check_field("pos_y", e.pos_y, rsp_pos_y);
            check_field("row_line_height", e.row_h, rsp_row_line_height);
            check_field("out_item_index", e.doc_item, rsp_out_item_index);
            check_field("out_text_offset", e.txt_pos, rsp_out_text_offset);
            check_field("out_word_length", e.word_length, rsp_out_word_length);
            check_field("out_heading_level", e.level, rsp_out_heading_level);
            check_field("out_link_index", e.link_ref, rsp_out_link_index);
            check_field("out_image_index", e.img_num, rsp_out_image_index);
         end
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_token(input token_type t);
      placement_type p;
      req_valid         <= 1'b1;
      req_action        <= t.action;
      req_heading_level <= t.level;
      req_word_length   <= t.word_length;
      req_text_offset   <= t.txt_pos;
      req_item_index    <= t.doc_item;
      req_link_index    <= t.link_ref;
      req_image_index   <= t.img_num;
      req_image_height  <= t.image_height;
      do @(posedge clock); while (!req_ready);
      if (place_token(t, p)) expected_placements.push_back(p);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
   endtask

   // drain all pending beats, then let tokens with no beat finish
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_placements.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input wwlp_pkg::cfg_type c);
      settle();
      write_reg(wwlp_pkg::REG_LINE_WIDTH, {20'd0, c.line_width});
      write_reg(wwlp_pkg::REG_GLYPH_WIDTH, {26'd0, c.glyph_width});
      write_reg(wwlp_pkg::REG_GLYPH_HEIGHT, {26'd0, c.glyph_height});
      write_reg(wwlp_pkg::REG_SCALE_DELTA, {23'd0, c.scale_delta});
      write_reg(wwlp_pkg::REG_DEF_IMG_H, {20'd0, c.default_image_height});
      settings_model = c;
   endtask

   // token with random pass-through content
   function automatic token_type tok(input logic [2:0] act, input logic [2:0] lvl,
                                     input logic [WLB-1:0] len);
      token_type t;
      t.action       = act;
      t.level        = lvl;
      t.word_length  = len;
      t.txt_pos      = 16'($urandom);
      t.doc_item     = 16'($urandom);
      t.link_ref     = ($urandom_range(0, 2) == 0) ? 16'($urandom) : -16'sd1;
      t.img_num      = 15'($urandom);
      t.image_height = ($urandom_range(0, 1) == 0) ? 12'($urandom) : 12'd0;
      return t;
   endfunction

   function automatic logic [WLB-1:0] random_length();
      if ($urandom_range(0, 9) == 0) return WLB'($urandom);
      return WLB'($urandom_range(1, 12));
   endfunction

   function automatic wwlp_pkg::cfg_type random_settings();
      wwlp_pkg::cfg_type c;
      c.line_width   = ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                                   : 12'($urandom_range(40, 480));
      c.glyph_width  = ($urandom_range(0, 3) == 0) ? 6'($urandom)
                                                   : 6'($urandom_range(1, 10));
      c.glyph_height = 6'($urandom_range(1, 63));
      c.scale_delta  = ($urandom_range(0, 3) == 0) ? 9'($urandom)
                                                   : 9'($urandom_range(0, 64) - 32);
      c.default_image_height = 12'($urandom_range(1, 4095));
      return c;
   endfunction

   // ---------------------------------------------------------------- tests

   // runs on reset register values
   task automatic test_directed_tokens();
      token_type t;
      send_idle_pct = 0;
      recv_stall_pct <= 0;
      send_token(tok(wwlp_pkg::ACT_SPACE, 3'd0, 8'd0));     // space on an empty row
      t = tok(wwlp_pkg::ACT_WORD, 3'd0, 8'd0);              // empty word, all-zero fields
      t.txt_pos  = '0;
      t.doc_item = '0;
      t.link_ref = '0;
      t.img_num  = '0;
      send_token(t);
      t = tok(wwlp_pkg::ACT_WORD, 3'd1, 8'd5);
      t.txt_pos  = 16'hFFFF;
      t.doc_item = 16'hFFFF;
      t.link_ref = 16'sh7FFF;
      t.img_num  = 15'h7FFF;
      send_token(t);
      send_token(tok(wwlp_pkg::ACT_SPACE, 3'd1, 8'd0));
      t = tok(wwlp_pkg::ACT_WORD, 3'd2, 8'd8);
      t.link_ref = -16'sd1;
      send_token(t);
      send_token(tok(wwlp_pkg::ACT_SPACE, 3'd2, 8'd0));
      send_token(tok(wwlp_pkg::ACT_WORD, 3'd3, 8'd200));    // overruns the line
      send_token(tok(wwlp_pkg::ACT_WORD, 3'd7, 8'd255));
      send_token(tok(wwlp_pkg::ACT_LINE, 3'd0, 8'd0));
      send_token(tok(wwlp_pkg::ACT_LINE, 3'd0, 8'd0));      // break on an empty row
      send_token(tok(wwlp_pkg::ACT_WORD, 3'd4, 8'd3));
      send_token(tok(wwlp_pkg::ACT_PARA, 3'd0, 8'd0));
      t = tok(wwlp_pkg::ACT_IMAGE, 3'd0, 8'd0);
      t.image_height = 12'd0;                               // not loaded yet
      send_token(t);
      send_token(tok(wwlp_pkg::ACT_WORD, 3'd0, 8'd4));
      t = tok(wwlp_pkg::ACT_IMAGE, 3'd5, 8'd9);
      t.image_height = 12'hFFF;
      t.img_num      = 15'h7FFF;
      send_token(t);
      send_token(tok(ACT_SPARE_A, 3'd1, 8'd9));
      send_token(tok(ACT_SPARE_B, 3'd2, 8'd9));
      send_token(tok(wwlp_pkg::ACT_WORD, 3'd0, 8'd52));
      send_token(tok(wwlp_pkg::ACT_SPACE, 3'd0, 8'd0));
      send_token(tok(wwlp_pkg::ACT_WORD, 3'd0, 8'd2));      // lands at the start of the row the overrun closed to
      send_token(tok(wwlp_pkg::ACT_END, 3'd0, 8'd0));
      send_token(tok(wwlp_pkg::ACT_END, 3'd0, 8'd0));       // empty document
   endtask

   task automatic test_register_corners();
      wwlp_pkg::cfg_type corners[3];
      corners[0] = '{12'd0, 6'd0, 6'd0, 9'h100, 12'd0};   // scale delta -256
      corners[1] = '{12'd4095, 6'd63, 6'd63, 9'sd255, 12'd4095};
      corners[2] = '{12'd1, 6'd1, 6'd1, -9'sd128, 12'd1};
      for (int k = 0; k < 3; k++) begin
         apply_settings(corners[k]);
         send_token(tok(wwlp_pkg::ACT_WORD, 3'd1, 8'd255));
         send_token(tok(wwlp_pkg::ACT_SPACE, 3'd1, 8'd0));
         send_token(tok(wwlp_pkg::ACT_WORD, 3'd0, 8'd1));
         send_token(tok(wwlp_pkg::ACT_IMAGE, 3'd0, 8'd0));
         send_token(tok(wwlp_pkg::ACT_PARA, 3'd0, 8'd0));
         send_token(tok(wwlp_pkg::ACT_END, 3'd0, 8'd0));
      end
   endtask

   // enough tall boxes to pin pen y at its ceiling
   task automatic test_y_saturation();
      token_type t;
      apply_settings('{12'd320, 6'd6, 6'd8, 9'sd128, 12'd4095});
      for (int k = 0; k < 258; k++) begin
         t = tok(wwlp_pkg::ACT_IMAGE, 3'd0, 8'd0);
         t.image_height = 12'd0;
         send_token(t);
      end
      send_token(tok(wwlp_pkg::ACT_WORD, 3'd1, 8'd4));
      send_token(tok(wwlp_pkg::ACT_LINE, 3'd0, 8'd0));
      send_token(tok(wwlp_pkg::ACT_WORD, 3'd0, 8'd4));
      send_token(tok(wwlp_pkg::ACT_PARA, 3'd0, 8'd0));
      send_token(tok(wwlp_pkg::ACT_END, 3'd0, 8'd0));
   endtask

   // rsp held off long enough for the result register to fill and req to stall
   task automatic test_output_backpressure();
      send_idle_pct = 0;
      recv_stall_pct <= 0;
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         for (int k = 0; k < 60; k++) begin
            if (k == 59) send_token(tok(wwlp_pkg::ACT_END, 3'd0, 8'd0));
            else if (k % 15 == 14) send_token(tok(wwlp_pkg::ACT_IMAGE, 3'd0, 8'd0));
            else if (k % 2 == 1) send_token(tok(wwlp_pkg::ACT_SPACE, 3'd0, 8'd0));
            else send_token(tok(wwlp_pkg::ACT_WORD, 3'($urandom_range(0, 7)),
                                random_length()));
         end
      join
   endtask

   task automatic test_random_documents(input int n_tokens, input int idle_pct,
                                        input int stall_pct);
      int         sent;
      int         pick;
      int         doc_len;
      logic [2:0] lvl;
      token_type  t;
      apply_settings(random_settings());
      send_idle_pct = idle_pct;
      recv_stall_pct <= stall_pct;
      sent = 0;
      while (sent < n_tokens) begin
         if ($urandom_range(0, 99) < 8) begin
            // noise: any code, any level, spare codes included
            t = tok(3'($urandom_range(0, 7)), 3'($urandom), random_length());
            send_token(t);
            if (t.action <= wwlp_pkg::ACT_END) sent++;
         end else begin
            doc_len = $urandom_range(4, 40);
            lvl = 3'($urandom);
            for (int k = 0; k < doc_len; k++) begin
               pick = $urandom_range(0, 99);
               if (pick < 55) t = tok(wwlp_pkg::ACT_WORD, lvl, random_length());
               else if (pick < 80) t = tok(wwlp_pkg::ACT_SPACE, lvl, random_length());
               else if (pick < 87) t = tok(wwlp_pkg::ACT_LINE, lvl, random_length());
               else if (pick < 93) t = tok(wwlp_pkg::ACT_PARA, lvl, random_length());
               else t = tok(wwlp_pkg::ACT_IMAGE, lvl, random_length());
               send_token(t);
               sent++;
               if (t.action == wwlp_pkg::ACT_PARA || t.action == wwlp_pkg::ACT_LINE) begin
                  lvl = 3'($urandom);
               end
            end
            // some documents are left open and run into the next one
            if ($urandom_range(0, 9) != 0) begin
               send_token(tok(wwlp_pkg::ACT_END, lvl, random_length()));
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_tokens();
      test_register_corners();
      test_y_saturation();
      test_output_backpressure();
      test_random_documents(330, 0, 0);
      test_random_documents(330, 78, 0);
      test_random_documents(330, 0, 78);
      test_random_documents(330, 6, 6);
      settle();
      if (mismatch_count == 0 && expected_placements.size() == 0) begin
         $display("word_wrap_layout_placer_tb: clean");
      end else begin
         $display("word_wrap_layout_placer_tb: errors");
      end
      $finish;
   end

endmodule
